### rtl/core/grain_crossfade_stretch_top_defines.svh
// Assertion macros shared by the grain crossfade stretch RTL.
`ifndef GRAIN_CROSSFADE_STRETCH_TOP_DEFINES_SVH
`define GRAIN_CROSSFADE_STRETCH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GCS_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("assertion failed");
`define GCS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define GCS_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define GCS_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

### rtl/core/gcs_pkg.sv
// Shared constants and types for the grain crossfade stretch block.
package gcs_pkg;
    localparam int HALF_GRAIN = 256;
    localparam int SAMPLE_W   = 8;
    localparam int IDX_W      = $clog2(HALF_GRAIN);
    localparam int PHASE_W    = IDX_W + 1;
    localparam int LEN_W      = 24;
    localparam int FRAC_W     = IDX_W;
    localparam int PROD_W     = SAMPLE_W + 1 + IDX_W + 1;
    localparam int BIAS       = HALF_GRAIN / 2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                past_end;
    } t_result;
endpackage

### rtl/core/gcs_tail_cell.sv
// One cell of the tail delay line: holds a sample, passes it on each shift.
module gcs_tail_cell
    import gcs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic [SAMPLE_W-1:0] o_sample
);
    logic [SAMPLE_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;
endmodule

### rtl/core/gcs_fade.sv
// Linear crossfade of the current sample against the stored tail sample.
module gcs_fade
    import gcs_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_prev,
    input  logic [SAMPLE_W-1:0] i_cur,
    input  logic [IDX_W-1:0]    i_idx,
    input  logic                i_blend,
    input  logic                i_past_end,
    output t_result             o_result
);
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_sum;
    logic signed [PROD_W-1:0]   w_quot;
    logic        [SAMPLE_W-1:0] w_faded;

    always_comb begin
        w_diff  = $signed({i_cur[SAMPLE_W-1], i_cur}) - $signed({i_prev[SAMPLE_W-1], i_prev});
        w_prod  = PROD_W'(w_diff) * PROD_W'($signed({1'b0, i_idx}));
        w_sum   = w_prod + PROD_W'(BIAS);
        w_quot  = w_sum >>> FRAC_W;
        // result lies between prev and cur, so the low bits are exact
        w_faded = i_prev + w_quot[SAMPLE_W-1:0];

        if (i_past_end) begin
            o_result.sample   = '0;
            o_result.past_end = 1'b1;
        end else begin
            o_result.sample   = i_blend ? w_faded : i_cur;
            o_result.past_end = 1'b0;
        end
    end
endmodule

### rtl/core/gcs_out_skid.sv
// Output register with a skid stage for the result stream.
`include "grain_crossfade_stretch_top_defines.svh"
module gcs_out_skid
    import gcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_pop_ready
);
    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    w_pop;

    assign w_pop    = r_main_valid & i_pop_ready;
    assign o_ready  = ~r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (i_push) begin
            if (!r_main_valid || w_pop) begin
                n_main       = i_result;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (w_pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    `GCS_ASSERT_IMPLY(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid, r_main_valid)
    `GCS_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, i_push && r_main_valid && !i_pop_ready, r_skid_valid)
    `GCS_ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n, w_pop && !i_push && !r_skid_valid, !r_main_valid)
    `GCS_ASSERT_IMPLY(a_no_push_when_full, i_clk, i_rst_n, r_skid_valid, !i_push)
endmodule

### rtl/core/grain_crossfade_stretch_top.sv
// Top level of the grain crossfade stretch block.
// Usage:
//   Input stream s_axis_*: one signed 8-bit grain sample per transaction,
//   512 samples per grain. Samples in the first half of a grain each give
//   one result transaction on m_axis_*; second-half samples give none and
//   refill the 256-sample tail delay line.
//   m_axis_tdata carries the crossfaded sample, m_axis_tuser the past-end
//   flag (sample forced to zero once total_length samples have gone out).
//   total_length is written through i_cfg_we / i_cfg_wdata while idle.
//   Throughput: one sample per cycle while s_axis_tready is high. Each result
//   takes one multiply, then enters the output register (or the skid stage).
//   The tail store is a chain of 256 cells shifted on every accepted sample.
//   When the receiver stalls, one result lands in a skid stage and
//   s_axis_tready drops until the stage drains; no transaction is lost.
//   Reset (synchronous, active low) clears the grain phase, the grain flag,
//   the output position and sets total_length to 1. The tail cells need
//   no clearing: they are filled before the first read.
`include "grain_crossfade_stretch_top_defines.svh"
module grain_crossfade_stretch_top
    import gcs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] grain_sample
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] out_sample
    output logic                m_axis_tuser,   // [0] past_end
    input  logic                i_cfg_we,
    input  logic [LEN_W-1:0]    i_cfg_wdata     // total_length
);
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic                r_grain_seen, n_grain_seen;
    logic [LEN_W-1:0]    r_out_pos, n_out_pos;
    logic [LEN_W-1:0]    r_total_len;

    logic                w_accept;
    logic                w_first_half;
    logic                w_past_end;
    logic                w_ready;
    logic [SAMPLE_W-1:0] w_tap [0:HALF_GRAIN];
    t_result             w_result;
    t_result             w_out;

    assign s_axis_tready = w_ready;
    assign w_accept      = s_axis_tvalid & w_ready;
    assign w_first_half  = ~r_phase[PHASE_W-1];
    assign w_past_end    = (r_out_pos >= r_total_len);

    assign w_tap[HALF_GRAIN] = s_axis_tdata;

    genvar k;
    generate
        for (k = 0; k < HALF_GRAIN; k++) begin : g_tail
            gcs_tail_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_accept),
                .i_sample (w_tap[k+1]),
                .o_sample (w_tap[k])
            );
        end
    endgenerate

    gcs_fade u_fade (
        .i_prev     (w_tap[0]),
        .i_cur      (s_axis_tdata),
        .i_idx      (r_phase[IDX_W-1:0]),
        .i_blend    (r_grain_seen),
        .i_past_end (w_past_end),
        .o_result   (w_result)
    );

    gcs_out_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept & w_first_half),
        .i_result    (w_result),
        .o_ready     (w_ready),
        .o_valid     (m_axis_tvalid),
        .o_result    (w_out),
        .i_pop_ready (m_axis_tready)
    );

    assign m_axis_tdata = w_out.sample;
    assign m_axis_tuser = w_out.past_end;

    always_comb begin
        n_phase      = r_phase;
        n_grain_seen = r_grain_seen;
        n_out_pos    = r_out_pos;
        if (w_accept) begin
            if (r_phase == PHASE_W'(2 * HALF_GRAIN - 1)) begin
                n_phase      = '0;
                n_grain_seen = 1'b1;
            end else begin
                n_phase = r_phase + 1'b1;
            end
            if (w_first_half && !w_past_end) begin
                n_out_pos = r_out_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_grain_seen <= 1'b0;
            r_out_pos    <= '0;
            r_total_len  <= LEN_W'(1);
        end else begin
            r_phase      <= n_phase;
            r_grain_seen <= n_grain_seen;
            r_out_pos    <= n_out_pos;
            if (i_cfg_we) begin
                r_total_len <= i_cfg_wdata;
            end
        end
    end

    `GCS_ASSERT_NEXT(a_phase_wrap, i_clk, i_rst_n, w_accept && r_phase == PHASE_W'(2 * HALF_GRAIN - 1), r_phase == '0 && r_grain_seen)
    `GCS_ASSERT_NEXT(a_pos_hold_second_half, i_clk, i_rst_n, !w_first_half, r_out_pos == $past(r_out_pos))
    `GCS_ASSERT_IMPLY(a_past_end_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
endmodule

### sim/tb_grain_crossfade_stretch_top.sv
// Self-checking testbench: grain crossfade stretch block against a local predictor.
`timescale 1ns / 100ps

module tb_grain_crossfade_stretch_top;
    import gcs_pkg::*;

    localparam int ITEM_TARGET   = 1050;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PRINT_CAP     = 30;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [SAMPLE_W-1:0] CORNER [8] = '{
        8'h00, 8'h7F, 8'h80, 8'hFF, 8'h01, 8'h55, 8'hAA, 8'hFE
    };

    class stretch_scoreboard;
        logic signed [SAMPLE_W-1:0] tail_mem [HALF_GRAIN];
        int unsigned      grain_pos;
        bit               grain_seen;
        logic [LEN_W-1:0] out_pos;
        logic [LEN_W-1:0] total_len;
        t_result          fade_queue [$];
        int               errors;
        int               n_checked;
        int               n_past_end;
        int               n_faded;

        function new();
            grain_pos  = 0;
            grain_seen = 0;
            out_pos    = '0;
            total_len  = 1;
            errors     = 0;
            n_checked  = 0;
            n_past_end = 0;
            n_faded    = 0;
        endfunction

        // one accepted input transaction
        function void take_sample(logic [SAMPLE_W-1:0] raw);
            int      cur;
            int      prev;
            int      v;
            t_result r;
            cur = int'($signed(raw));
            if (grain_pos < HALF_GRAIN) begin
                if (out_pos >= total_len) begin
                    r.sample   = '0;
                    r.past_end = 1'b1;
                    n_past_end++;
                end else begin
                    v = cur;
                    if (grain_seen) begin
                        prev = int'(tail_mem[grain_pos]);
                        // arithmetic shift gives the floor of the biased quotient
                        v = prev + (((cur - prev) * int'(grain_pos) + BIAS) >>> FRAC_W);
                        n_faded++;
                    end
                    r.sample   = v[SAMPLE_W-1:0];
                    r.past_end = 1'b0;
                    out_pos    = out_pos + 1'b1;
                end
                fade_queue.push_back(r);
            end else begin
                tail_mem[grain_pos - HALF_GRAIN] = raw;
            end
            if (grain_pos == 2 * HALF_GRAIN - 1) begin
                grain_pos  = 0;
                grain_seen = 1;
            end else begin
                grain_pos++;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_CAP) begin
                $display("mismatch at result %0d: %s", n_checked, msg);
            end
        endtask

        task check_output(logic [SAMPLE_W-1:0] data, logic flag);
            t_result e;
            n_checked++;
            if (fade_queue.size() == 0) begin
                report_mismatch("result with nothing pending");
                return;
            end
            e = fade_queue.pop_front();
            if (data !== e.sample) begin
                report_mismatch($sformatf("out_sample got %0d, expected %0d",
                                          $signed(data), $signed(e.sample)));
            end
            if (flag !== e.past_end) begin
                report_mismatch($sformatf("past_end got %0b, expected %0b",
                                          flag, e.past_end));
            end
        endtask
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = '0;   // [7:0] grain_sample
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;         // [7:0] out_sample
    logic                m_axis_tuser;         // [0] past_end
    logic                i_cfg_we      = 1'b0;
    logic [LEN_W-1:0]    i_cfg_wdata   = '0;

    stretch_scoreboard sb;
    int n_sent      = 0;
    int n_cfg       = 0;
    int burst_left  = 0;
    int quiet_cycles = 0;
    int rx_mode     = 0;
    int rx_left     = 0;

    grain_crossfade_stretch_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // receiver stall modes, switched when rx_left runs out
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(50, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ((rx_left % 8) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_output(m_axis_tdata, m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 8'h7F;
            1: return 8'h80;
            2: return 8'($urandom_range(254, 258));  // -2 .. 2
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_sample(s);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 24);
        end
    endtask

    // hold input until all pending results are out
    task automatic settle_idle();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
        end
        @(posedge i_clk);
        while (sb.fade_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.total_len = v;
        i_cfg_we <= 1'b0;
        n_cfg++;
    endtask

    initial begin
        int chunk;
        int phase_idx;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = 5;

        // reset length of 1: first result passes, the rest are past the end
        foreach (CORNER[k]) send_sample(CORNER[k]);
        settle_idle();
        write_length('0);
        foreach (CORNER[k]) send_sample(CORNER[k]);
        settle_idle();
        write_length(LEN_MAX);
        foreach (CORNER[k]) send_sample(CORNER[k]);

        phase_idx = 0;
        while (n_sent < ITEM_TARGET) begin
            settle_idle();
            chunk = $urandom_range(80, 200);
            case (phase_idx % 4)
                0: write_length(LEN_MAX);
                1: write_length(sb.out_pos + LEN_W'($urandom_range(0, 40)));
                2: write_length(LEN_W'($urandom));
                default: begin
                    write_length(LEN_W'(1));
                    chunk = $urandom_range(20, 40);
                end
            endcase
            if (chunk > ITEM_TARGET - n_sent) begin
                chunk = ITEM_TARGET - n_sent;
            end
            repeat (chunk) send_sample(pick_sample());
            phase_idx++;
        end
        settle_idle();

        $display("run: %0d samples in, %0d results (%0d crossfaded, %0d past end)",
                 n_sent, sb.n_checked, sb.n_faded, sb.n_past_end);
        $display("run: %0d length writes, %0d grains completed, %0d mismatches",
                 n_cfg, n_sent / (2 * HALF_GRAIN), sb.errors);
        if (sb.errors == 0 && sb.fade_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
